// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion that is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- design/mapf_pkg.sv -----
package mapf_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int RANGE_W    = 16;
    localparam int POS_W      = 16;
    localparam int ERR_W      = 17;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Full scale is 2**DIV_SHIFT - 1, which the scaler uses for its division.
    localparam int FULL_SCALE = 4095;
    localparam int DIV_SHIFT  = 12;
    localparam int DEADBAND   = 5;
    localparam int MAX_STEPS  = 10;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd6400;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 4'd1;

    // What a word does once it reaches the tracking stage.
    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_HOLD,
        KIND_TRACK
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SAMPLE_W-1:0]  median;
    } t_tag;

endpackage

// ----- design/median_adc_position_follower.sv -----
// Median-filtered converter position follower. Every input word carries an
// opcode and a 12-bit converter sample. While enabled, a sample word is
// written into a WINDOW-entry ring, the upper median of the entries written
// so far is mapped onto a target of minus to plus half the travel range, and
// when the target is more than five steps away from the tracked position the
// block issues up to ten steps toward it. A clear word zeroes the tracked
// position, and a sample word that arrives while disabled changes nothing.
// Every input word gives exactly one result word. The block accepts one word
// per clock while the output side is not stalled and holds up to five words
// in flight. The stages are the input register, the rank-compare median with
// the ring update, the scaling multiply, the division by full scale, and the
// tracking stage whose position loop sets the sustained rate.
// Configuration writes take effect at once and are meant for a quiet block.

`include "assert_macros.svh"

module median_adc_position_follower #(
    parameter int WINDOW = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic [mapf_pkg::SAMPLE_W-1:0]        i_sample,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mapf_pkg::SAMPLE_W-1:0]        o_median_value,
    output logic signed [mapf_pkg::POS_W-1:0]    o_target_position,
    output logic signed [mapf_pkg::ERR_W-1:0]    o_tracking_error,
    output logic [mapf_pkg::STEP_W-1:0]          o_step_count,
    output logic                                 o_step_direction,
    output logic signed [mapf_pkg::POS_W-1:0]    o_tracked_position,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mapf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mapf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mapf_pkg::*;

    // Configuration registers.
    logic               r_enable;
    logic [RANGE_W-1:0] r_range;

    // Input register; the sample payload needs no reset.
    logic                r_in_op;
    logic [SAMPLE_W-1:0] r_in_sample;

    // One valid bit per stage: input, median, product, target, output.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic in_acc, out_acc, cfg_acc;
    logic mv01, mv12, mv23, mv34;

    t_tag                    med_tag, tgt_tag;
    logic signed [POS_W-1:0] tgt_value;

    // A stage can take a new word when it is empty or when its own word moves
    // on in the same cycle, so bubbles close up behind a stalled output.
    assign rdy4 = !r_v4 || i_out_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign mv01 = r_v0 && rdy1;
    assign mv12 = r_v1 && rdy2;
    assign mv23 = r_v2 && rdy3;
    assign mv34 = r_v3 && rdy4;

    assign o_in_ready  = rdy0;
    assign o_out_valid = r_v4;
    assign o_cfg_ready = 1'b1;

    assign in_acc  = i_in_valid && rdy0;
    assign out_acc = r_v4 && i_out_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= (r_v0 && !mv01) || in_acc;
            r_v1 <= (r_v1 && !mv12) || mv01;
            r_v2 <= (r_v2 && !mv23) || mv12;
            r_v3 <= (r_v3 && !mv34) || mv23;
            r_v4 <= (r_v4 && !out_acc) || mv34;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_op     <= i_opcode;
            r_in_sample <= i_sample;
        end
    end

    // Writes to an index outside the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_range  <= RANGE_RESET;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_enable <= i_cfg_data[0];
                REG_RANGE:  r_range  <= i_cfg_data[RANGE_W-1:0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // The ring is written, and the word classified, as it leaves the input
    // register, so the next word already sees the updated ring.
    mapf_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mv01),
        .i_opcode (r_in_op),
        .i_sample (r_in_sample),
        .i_enable (r_enable),
        .o_tag    (med_tag)
    );

    mapf_scale u_scale (
        .i_clk     (i_clk),
        .i_ld_prod (mv12),
        .i_ld_tgt  (mv23),
        .i_tag     (med_tag),
        .i_range   (r_range),
        .o_tag     (tgt_tag),
        .o_target  (tgt_value)
    );

    // The tracked position is updated only here, in word order.
    mapf_track u_track (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (mv34),
        .i_tag              (tgt_tag),
        .i_target           (tgt_value),
        .o_median_value     (o_median_value),
        .o_target_position  (o_target_position),
        .o_tracking_error   (o_tracking_error),
        .o_step_count       (o_step_count),
        .o_step_direction   (o_step_direction),
        .o_tracked_position (o_tracked_position)
    );

    // A result never asks for more steps than one word may issue.
    `ASSERT_IMPLIES(a_step_limit, i_clk, i_rst_n, o_out_valid,
        o_step_count <= STEP_W'(MAX_STEPS), "step count above limit")

    // Steps are issued only for an error outside the deadband.
    `ASSERT_IMPLIES(a_deadband, i_clk, i_rst_n, o_out_valid && (o_step_count != '0),
        (o_tracking_error > 17'sd5) || (o_tracking_error < -17'sd5),
        "steps issued inside the deadband")

    // Stepping goes toward the target.
    `ASSERT_IMPLIES(a_direction, i_clk, i_rst_n, o_out_valid && (o_step_count != '0),
        o_step_direction == (o_tracking_error > 17'sd0), "step direction wrong")

    // A word handed to the tracking stage shows up as a result next cycle.
    `ASSERT_NEXT(a_delivery, i_clk, i_rst_n, mv34, o_out_valid,
        "tracked word lost before the output")

endmodule

// ----- design/mapf_median.sv -----
module mapf_median #(
    parameter int WINDOW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_opcode,
    input  logic [mapf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_enable,
    output mapf_pkg::t_tag                o_tag
);
    import mapf_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_full, n_full;
    t_tag                r_tag, n_tag;

    logic                store;
    logic [SAMPLE_W-1:0] entry [WINDOW];
    logic [CNT_W-1:0]    cnt;
    logic [WINDOW-1:0]   live;
    logic [WINDOW-1:0]   below [WINDOW];
    logic [WINDOW-1:0]   hit;
    logic [SAMPLE_W-1:0] med;

    // The median is ranked over the ring as it stands after this sample.
    always_comb begin
        store = (i_opcode == OP_SAMPLE) && i_enable;
        cnt   = r_full ? CNT_W'(WINDOW) : (CNT_W'(r_slot) + CNT_W'(store));
        for (int i = 0; i < WINDOW; i++) begin
            entry[i] = (store && (r_slot == SLOT_W'(i))) ? i_sample : r_ring[i];
            live[i]  = CNT_W'(i) < cnt;
        end
        // Equal values are ordered by slot so that every rank is unique.
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                below[i][j] = live[j] && ((entry[j] < entry[i]) ||
                              ((entry[j] == entry[i]) && (j < i)));
            end
            hit[i] = live[i] && (CNT_W'($countones(below[i])) == (cnt >> 1));
        end
        med = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (hit[i]) begin
                med = med | entry[i];
            end
        end
    end

    always_comb begin
        n_slot = r_slot;
        n_full = r_full;
        if (store) begin
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
            n_full = r_full || (r_slot == LAST_SLOT);
        end
        if (i_opcode == OP_CLEAR) begin
            n_tag.kind = KIND_CLEAR;
        end else if (i_enable) begin
            n_tag.kind = KIND_TRACK;
        end else begin
            n_tag.kind = KIND_HOLD;
        end
        n_tag.median = med;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
        end else if (i_load) begin
            r_slot <= n_slot;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tag <= n_tag;
            if (store) begin
                r_ring[r_slot] <= i_sample;
            end
        end
    end

    assign o_tag = r_tag;

endmodule

// ----- design/mapf_scale.sv -----
module mapf_scale (
    input  logic                          i_clk,
    input  logic                          i_ld_prod,
    input  logic                          i_ld_tgt,
    input  mapf_pkg::t_tag                i_tag,
    input  logic [mapf_pkg::RANGE_W-1:0]  i_range,
    output mapf_pkg::t_tag                o_tag,
    output logic signed [mapf_pkg::POS_W-1:0] o_target
);
    import mapf_pkg::*;

    localparam int PROD_W = SAMPLE_W + RANGE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - DIV_SHIFT;
    localparam int R_W    = PROD_W + 2;

    logic [RANGE_W-2:0] half;
    logic [RANGE_W-1:0] span;

    t_tag               r_prod_tag;
    logic [PROD_W-1:0]  r_prod, n_prod;
    t_tag               r_tgt_tag;
    logic signed [POS_W-1:0] r_target, n_target;

    logic [SUM_W-1:0]   approx;
    logic [Q_W-1:0]     q_est, quot;
    logic [R_W-1:0]     rem;
    logic [Q_W-1:0]     diff;

    assign half = i_range[RANGE_W-1:1];
    assign span = {half, 1'b0};

    assign n_prod = PROD_W'(i_tag.median) * PROD_W'(span);

    // Division by 2**12 - 1: the geometric series gives a quotient that is at
    // most one short, and the remainder check adds the missing one.
    always_comb begin
        approx = SUM_W'(r_prod) + SUM_W'(r_prod >> DIV_SHIFT)
               + SUM_W'(r_prod >> (2 * DIV_SHIFT));
        q_est  = Q_W'(approx >> DIV_SHIFT);
        rem    = R_W'(r_prod) + R_W'(q_est) - (R_W'(q_est) << DIV_SHIFT);
        quot   = (rem >= R_W'(FULL_SCALE)) ? q_est + Q_W'(1) : q_est;
        diff   = quot - Q_W'(half);
        n_target = (r_prod_tag.kind == KIND_TRACK) ? $signed(diff[POS_W-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_prod) begin
            r_prod_tag <= i_tag;
            r_prod     <= n_prod;
        end
        if (i_ld_tgt) begin
            r_tgt_tag <= r_prod_tag;
            r_target  <= n_target;
        end
    end

    assign o_tag    = r_tgt_tag;
    assign o_target = r_target;

endmodule

// ----- design/mapf_track.sv -----
module mapf_track (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  mapf_pkg::t_tag                     i_tag,
    input  logic signed [mapf_pkg::POS_W-1:0]  i_target,
    output logic [mapf_pkg::SAMPLE_W-1:0]      o_median_value,
    output logic signed [mapf_pkg::POS_W-1:0]  o_target_position,
    output logic signed [mapf_pkg::ERR_W-1:0]  o_tracking_error,
    output logic [mapf_pkg::STEP_W-1:0]        o_step_count,
    output logic                               o_step_direction,
    output logic signed [mapf_pkg::POS_W-1:0]  o_tracked_position
);
    import mapf_pkg::*;

    logic signed [POS_W-1:0] r_pos, n_pos;
    logic [SAMPLE_W-1:0]     r_median;
    logic signed [POS_W-1:0] r_target, n_target;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [STEP_W-1:0]       r_steps, n_steps;
    logic                    r_dir, n_dir;

    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        mag;
    logic                    beyond;
    logic [STEP_W-1:0]       steps;

    always_comb begin
        err    = ERR_W'(i_target) - ERR_W'(r_pos);
        mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        beyond = mag > ERR_W'(DEADBAND);
        steps  = (mag > ERR_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : mag[STEP_W-1:0];

        n_target = '0;
        n_err    = '0;
        n_steps  = '0;
        n_dir    = 1'b0;
        n_pos    = r_pos;
        case (i_tag.kind)
            KIND_CLEAR: begin
                n_pos = '0;
            end
            KIND_TRACK: begin
                n_target = i_target;
                n_err    = err;
                if (beyond) begin
                    n_steps = steps;
                    n_dir   = !err[ERR_W-1];
                    n_pos   = err[ERR_W-1] ? r_pos - POS_W'(steps) : r_pos + POS_W'(steps);
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_load) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_median <= i_tag.median;
            r_target <= n_target;
            r_err    <= n_err;
            r_steps  <= n_steps;
            r_dir    <= n_dir;
        end
    end

    assign o_median_value     = r_median;
    assign o_target_position  = r_target;
    assign o_tracking_error   = r_err;
    assign o_step_count       = r_steps;
    assign o_step_direction   = r_dir;
    assign o_tracked_position = r_pos;

endmodule

// ----- test/median_adc_position_follower_tb.sv -----
// Testbench for the median-filtered position follower. Words go in through a
// driver that drains a queue of pending words, and results come out through a
// monitor that checks each result word against the oldest prediction. The
// prediction is made at the moment the block accepts a word, from a private
// copy of the sample ring, the tracked position and the two registers.

module median_adc_position_follower_tb;

    import mapf_pkg::*;

    localparam int WINDOW      = 8;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 105;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;

    // An index that decodes to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } t_follow_word;

    typedef struct packed {
        logic        [SAMPLE_W-1:0] median;
        logic signed [POS_W-1:0]    target;
        logic signed [ERR_W-1:0]    err;
        logic        [STEP_W-1:0]   steps;
        logic                       dir;
        logic signed [POS_W-1:0]    tracked;
    } t_follow_result;

    // Everything the block sees is driven to a known value from time zero.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       i_opcode = OP_SAMPLE;
    logic [SAMPLE_W-1:0]        i_sample = '0;
    logic                       i_out_ready = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    logic                       o_in_ready;
    logic                       o_out_valid;
    logic [SAMPLE_W-1:0]        o_median_value;
    logic signed [POS_W-1:0]    o_target_position;
    logic signed [ERR_W-1:0]    o_tracking_error;
    logic [STEP_W-1:0]          o_step_count;
    logic                       o_step_direction;
    logic signed [POS_W-1:0]    o_tracked_position;
    logic                       o_cfg_ready;

    median_adc_position_follower #(
        .WINDOW (WINDOW)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_sample           (i_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_median_value     (o_median_value),
        .o_target_position  (o_target_position),
        .o_tracking_error   (o_tracking_error),
        .o_step_count       (o_step_count),
        .o_step_direction   (o_step_direction),
        .o_tracked_position (o_tracked_position),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Words waiting to be offered, and results waiting to be seen.
    t_follow_word   pending_words[$];
    t_follow_result expected_moves[$];
    int             queued_words = 0;
    int             accepted_words = 0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    // Idling controls. The quiet flags turn off random gaps on one side; a
    // long hold is requested by bumping hold_requests, and the monitor grants
    // it by counting the stall out in its own process.
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    int   hold_requests = 0;
    int   hold_grants = 0;
    int   send_gap = 0;
    int   recv_stall = 0;

    // Private copy of the block's state and registers, at their reset values.
    logic [SAMPLE_W-1:0] ring_samples[WINDOW] = '{default: '0};
    logic [2:0]          ring_slot = '0;
    logic                ring_wrapped = 1'b0;
    int                  follow_pos = 0;
    logic                cfg_enable = 1'b0;
    logic [RANGE_W-1:0]  cfg_range = RANGE_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_sample(int v);
        if (v < 0) return 0;
        if (v > FULL_SCALE) return FULL_SCALE;
        return v;
    endfunction

    // Upper median of the entries written so far: sort a copy and take the
    // element of rank n/2. Entries beyond n are never looked at.
    function automatic logic [SAMPLE_W-1:0] ring_median();
        logic [SAMPLE_W-1:0] sorted[WINDOW];
        logic [SAMPLE_W-1:0] tmp;
        int                  n;
        n = ring_wrapped ? WINDOW : int'(ring_slot);
        if (n == 0) return '0;
        for (int i = 0; i < WINDOW; i++) sorted[i] = ring_samples[i];
        for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
                tmp         = sorted[j];
                sorted[j]   = sorted[j-1];
                sorted[j-1] = tmp;
            end
        end
        return sorted[n/2];
    endfunction

    // Works out the result of one accepted word and advances the private state.
    function automatic t_follow_result track_word(logic op, logic [SAMPLE_W-1:0] smp);
        t_follow_result r;
        longint         half;
        longint         tgt;
        longint         diff;
        longint         mag;
        int             steps;
        r = '0;
        if (op == OP_CLEAR) begin
            // A clear zeroes the position whatever the enable says.
            follow_pos = 0;
            r.median   = ring_median();
        end else if (!cfg_enable) begin
            // A disabled sample is dropped; only the stored median is shown.
            r.median = ring_median();
        end else begin
            ring_samples[ring_slot] = smp;
            ring_slot = ring_slot + 3'd1;
            if (ring_slot == 3'd0) ring_wrapped = 1'b1;
            r.median = ring_median();
            half     = longint'(cfg_range) / 2;
            tgt      = (longint'(r.median) * 2 * half) / FULL_SCALE - half;
            diff     = tgt - longint'(follow_pos);
            mag      = diff < 0 ? -diff : diff;
            r.target = tgt[POS_W-1:0];
            r.err    = diff[ERR_W-1:0];
            // Inside the deadband the error is reported but nothing moves.
            if (mag > DEADBAND) begin
                steps   = mag > MAX_STEPS ? MAX_STEPS : int'(mag);
                r.steps = steps[STEP_W-1:0];
                r.dir   = diff > 0;
                follow_pos = diff > 0 ? follow_pos + steps : follow_pos - steps;
            end
        end
        r.tracked = follow_pos[POS_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string what, longint want, longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    // Driver. At each edge it first retires the word the block took, then
    // decides what to offer next. Valid is assigned once per edge at most, so
    // a word that follows straight on keeps valid high without a dip.
    always @(posedge i_clk) begin
        t_follow_word nxt;
        logic         load;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            load = 1'b0;
            nxt  = '0;
            if (i_in_valid && o_in_ready) begin
                expected_moves.push_back(track_word(i_opcode, i_sample));
                accepted_words++;
                send_gap = tx_quiet ? 0 : draw_gap();
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0) begin
                    nxt  = pending_words.pop_front();
                    load = 1'b1;
                end
                i_in_valid <= load;
                if (load) begin
                    i_opcode <= nxt.op;
                    i_sample <= nxt.sample;
                end
            end
        end
    end

    // Monitor. Checks the result word taken at this edge, then decides whether
    // to be ready for the next one.
    always @(posedge i_clk) begin
        t_follow_result want;
        logic           rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with none expected, median %0d",
                             $time, o_median_value);
                end else begin
                    want = expected_moves.pop_front();
                    check_field("median_value", want.median, o_median_value);
                    check_field("target_position", want.target, o_target_position);
                    check_field("tracking_error", want.err, o_tracking_error);
                    check_field("step_count", want.steps, o_step_count);
                    check_field("step_direction", want.dir, o_step_direction);
                    check_field("tracked_position", want.tracked, o_tracked_position);
                end
            end
            if (hold_requests != hold_grants) begin
                hold_grants++;
                recv_stall = LONG_HOLD;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
                rdy = 1'b1;
            end else begin
                recv_stall = draw_gap();
                rdy = (recv_stall == 0);
            end
            i_out_ready <= rdy;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_word(logic op, int smp);
        t_follow_word w;
        w.op     = op;
        w.sample = smp[SAMPLE_W-1:0];
        pending_words.push_back(w);
        queued_words++;
    endtask

    // Returns once every queued word is taken and every result has come back.
    task automatic wait_drained();
        while (accepted_words != queued_words || expected_moves.size() != 0)
            @(posedge i_clk);
    endtask

    // Register write over the configuration channel; only called while quiet.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_ENABLE) cfg_enable = data[0];
        else if (idx == REG_RANGE) cfg_range = data;
    endtask

    initial begin
        int          level;
        int          r;
        int unsigned range_v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the block is disabled: samples are dropped and the
        // median of an empty ring reads zero. A clear still zeroes position.
        push_word(OP_SAMPLE, FULL_SCALE);
        push_word(OP_CLEAR, FULL_SCALE);
        push_word(OP_SAMPLE, 0);
        wait_drained();

        // Directed run at the reset travel range. The first sample lands
        // just inside the deadband, the second a few steps out of it, then
        // the field extremes and alternating bit patterns, a wrap of the
        // ring, and clears with samples of both polarities on the bus.
        write_reg(REG_ENABLE, 16'd1);
        push_word(OP_SAMPLE, 2050);
        push_word(OP_SAMPLE, 2052);
        push_word(OP_SAMPLE, 0);
        push_word(OP_SAMPLE, FULL_SCALE);
        push_word(OP_SAMPLE, 12'hAAA);
        push_word(OP_SAMPLE, 12'h555);
        push_word(OP_SAMPLE, FULL_SCALE);
        push_word(OP_SAMPLE, FULL_SCALE);
        push_word(OP_SAMPLE, FULL_SCALE);
        push_word(OP_SAMPLE, 0);
        push_word(OP_CLEAR, 0);
        push_word(OP_SAMPLE, 0);
        push_word(OP_SAMPLE, 0);
        push_word(OP_SAMPLE, 0);
        push_word(OP_CLEAR, FULL_SCALE);
        push_word(OP_SAMPLE, 1);
        push_word(OP_SAMPLE, FULL_SCALE - 1);
        wait_drained();

        // Disabled with a full ring: the sample is ignored, the clear is not.
        write_reg(REG_ENABLE, 16'd0);
        push_word(OP_SAMPLE, 123);
        push_word(OP_CLEAR, 0);
        push_word(OP_SAMPLE, FULL_SCALE);
        wait_drained();
        write_reg(REG_SPARE, 16'hFFFF);

        // Random phases, each at its own travel range. Samples mostly follow
        // a slowly drifting level so the position can catch up and settle in
        // the deadband; the rest are outliers, extremes and clears.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       range_v = 20;
                1:       range_v = 0;
                2:       range_v = 1;
                3:       range_v = 6400;
                4:       range_v = 2;
                5:       range_v = 3;
                6:       range_v = 100;
                7:       range_v = 50000;
                8:       range_v = 65535;
                9:       range_v = 6400;
                10:      range_v = $urandom_range(1, 65535);
                default: range_v = 11;
            endcase
            write_reg(REG_RANGE, range_v[CFG_DATA_W-1:0]);
            write_reg(REG_ENABLE, phase == 9 ? 16'd0 : 16'd1);

            // Phase 3 fills the block behind a long receiver hold while the
            // sender keeps offering; phase 6 runs with no idling at all.
            tx_quiet = (phase == 3 || phase == 6);
            rx_quiet = (phase == 6);
            if (phase == 3) hold_requests++;

            level = $urandom_range(0, FULL_SCALE);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    push_word(OP_CLEAR, $urandom_range(0, FULL_SCALE));
                end else if (r < 16) begin
                    push_word(OP_SAMPLE, $urandom_range(0, FULL_SCALE));
                end else if (r < 20) begin
                    push_word(OP_SAMPLE, r[0] ? FULL_SCALE : 0);
                end else begin
                    level = clamp_sample(level + $urandom_range(0, 64) - 32);
                    push_word(OP_SAMPLE, clamp_sample(level + $urandom_range(0, 6) - 3));
                end
                // Now and then the sender stops until everything is back.
                if (k % 35 == 34 && $urandom_range(0, 1) == 1) wait_drained();
            end
            wait_drained();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && expected_moves.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/mapf_pkg.sv
design/mapf_median.sv
design/mapf_scale.sv
design/mapf_track.sv
design/median_adc_position_follower.sv
test/median_adc_position_follower_tb.sv
